### rtl/core/isuc_pkg.sv
package isuc_pkg;

   localparam int SET_DEPTH = 256;
   localparam int ADDR_W    = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
   localparam int COUNT_W   = $clog2(SET_DEPTH + 1);
   localparam int VALUE_W   = 32;
   localparam int OUT_CNT_W = 9;

   typedef enum logic [1:0] {
      ACT_CLEAR = 2'd0,
      ACT_ADD   = 2'd1,
      ACT_TEST  = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic               wr_en;
      logic [ADDR_W-1:0]  wr_addr;
      logic [VALUE_W-1:0] wr_data;
      logic               rd_en;
      logic [ADDR_W-1:0]  rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic                 found;
      logic                 stored_new;
      logic                 store_full;
      logic                 run_done;
      logic                 subset;
      logic [OUT_CNT_W-1:0] stored_count;
   } res_type;

endpackage

### rtl/core/isuc_store.sv
module isuc_store import isuc_pkg::*; (
   input  logic               clock,
   input  mem_req_type        mem_req,
   output logic [VALUE_W-1:0] rd_data
);

   logic [VALUE_W-1:0] mem_ff [SET_DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/isuc_ctrl.sv
module isuc_ctrl import isuc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_action,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      req_last_in_run,
   output mem_req_type               mem_req,
   input  logic [VALUE_W-1:0]        rd_data,
   output logic                      res_valid,
   input  logic                      res_stall,
   output res_type                   res
);

   state_type          state_ff, state_in;
   logic [1:0]         action_ff, action_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic               last_ff, last_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] idx_ff, idx_in;
   logic               pending_ff, pending_in;
   logic               found_ff, found_in;
   logic               run_ff, run_in;
   logic               accept;
   logic               hit;
   logic               issue;
   logic               scan_op;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign hit       = (state_ff == ST_SCAN) && pending_ff && (rd_data == value_ff);
   assign issue     = (state_ff == ST_SCAN) && (idx_ff < count_ff) && !hit;
   assign scan_op   = (req_action == ACT_ADD) || (req_action == ACT_TEST);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (scan_op && count_ff != '0) ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            if (hit || (!issue && !pending_ff)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!res_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      action_in  = action_ff;
      value_in   = value_ff;
      last_in    = last_ff;
      idx_in     = idx_ff;
      pending_in = 1'b0;
      found_in   = found_ff;
      count_in   = count_ff;
      run_in     = run_ff;
      mem_req    = '0;
      res_valid  = 1'b0;
      res        = '0;
      mem_req.rd_addr = idx_ff[ADDR_W-1:0];
      mem_req.wr_addr = count_ff[ADDR_W-1:0];
      mem_req.wr_data = value_ff;

      if (accept) begin
         action_in = req_action;
         value_in  = $unsigned(req_value);
         last_in   = req_last_in_run;
         idx_in    = '0;
         found_in  = 1'b0;
      end

      if (issue) begin
         mem_req.rd_en = 1'b1;
         idx_in        = idx_ff + 1'b1;
         pending_in    = 1'b1;
      end
      if (hit) begin
         found_in = 1'b1;
      end

      if (state_ff == ST_DONE) begin
         res_valid = 1'b1;
         case (action_ff)
            ACT_CLEAR: begin
               count_in = '0;
               run_in   = 1'b1;
            end
            ACT_ADD: begin
               res.found = found_ff;
               if (!found_ff) begin
                  if (count_ff < COUNT_W'(SET_DEPTH)) begin
                     mem_req.wr_en  = !res_stall;
                     count_in       = count_ff + 1'b1;
                     res.stored_new = 1'b1;
                  end else begin
                     res.store_full = 1'b1;
                  end
               end
            end
            ACT_TEST: begin
               res.found    = found_ff;
               res.subset   = run_ff && found_ff;
               res.run_done = last_ff;
               run_in       = last_ff ? 1'b1 : (run_ff && found_ff);
            end
            default: ;
         endcase
         res.stored_count = OUT_CNT_W'(count_in);
         if (res_stall) begin
            count_in = count_ff;
            run_in   = run_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         run_ff     <= 1'b1;
         pending_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         run_ff     <= run_in;
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff <= action_in;
      value_ff  <= value_in;
      last_ff   <= last_in;
      idx_ff    <= idx_in;
      found_ff  <= found_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(SET_DEPTH))
      else $error("element count beyond depth");

   a_write_not_found: assert property (@(posedge clock) disable iff (reset)
      mem_req.wr_en |-> (state_ff == ST_DONE) && !found_ff && (action_ff == ACT_ADD))
      else $error("store written outside a fresh add");

   a_hit_finishes: assert property (@(posedge clock) disable iff (reset)
      hit |=> state_ff == ST_DONE)
      else $error("match did not end the scan");

   a_res_to_idle: assert property (@(posedge clock) disable iff (reset)
      (res_valid && !res_stall) |=> state_ff == ST_IDLE)
      else $error("result taken but block not idle");

endmodule

### rtl/core/integer_set_union_contain_top.sv
// channel   valid      stall      payload
// request   req_valid  req_stall  req_action, req_value, req_last_in_run
// response  rsp_valid  rsp_stall  rsp_found, rsp_stored_new, rsp_store_full,
//                                 rsp_run_done, rsp_subset, rsp_stored_count
// Add and test on a non-empty set scan the stored elements between accept and
// the next accept, ending early on a match: one stored element is read per cycle
// through the memory port. Add and test on an empty set, clear and unused
// codes skip the scan and go straight to the done state.
// Reset empties the set and re-arms the subset flag; memory contents are kept.
// A held response does not block a new request; a result waits only when
// the response register is still full and stalled.
module integer_set_union_contain_top import isuc_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_action,
   input  logic signed [VALUE_W-1:0]   req_value,
   input  logic                        req_last_in_run,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_found,
   output logic                        rsp_stored_new,
   output logic                        rsp_store_full,
   output logic                        rsp_run_done,
   output logic                        rsp_subset,
   output logic [OUT_CNT_W-1:0]        rsp_stored_count
);

   mem_req_type        mem_req;
   logic [VALUE_W-1:0] rd_data;
   logic               res_valid;
   logic               res_stall;
   res_type            res;
   logic               rsp_valid_ff, rsp_valid_in;
   res_type            rsp_ff, rsp_in;

   isuc_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   isuc_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_value       (req_value),
      .req_last_in_run (req_last_in_run),
      .mem_req         (mem_req),
      .rd_data         (rd_data),
      .res_valid       (res_valid),
      .res_stall       (res_stall),
      .res             (res)
   );

   assign res_stall = rsp_valid_ff && rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (!res_stall) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_ff.found;
   assign rsp_stored_new   = rsp_ff.stored_new;
   assign rsp_store_full   = rsp_ff.store_full;
   assign rsp_run_done     = rsp_ff.run_done;
   assign rsp_subset       = rsp_ff.subset;
   assign rsp_stored_count = rsp_ff.stored_count;

endmodule
